[hdl/deadline_multilevel_feedback_scheduler_top_macros.svh]
// assertion macros for the scheduler
`ifndef DEADLINE_MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
`define DEADLINE_MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define DMFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication
`define DMFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

[hdl/dmfs_pkg.sv]
// shared types, constants and codes of the scheduler
`default_nettype none
package dmfs_pkg;
   localparam int LEVELS      = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;

   localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int NLEV_W  = $clog2(LEVELS + 1);
   localparam int QCOUNT_W = $clog2(LEVELS * QUEUE_DEPTH + 1);
   localparam int NDEAD_W = $clog2(LEVELS + 1);

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_COMPLETED  = 3'd1;
   localparam logic [2:0] EV_DEMOTED    = 3'd2;
   localparam logic [2:0] EV_FAILED     = 3'd3;
   localparam logic [2:0] EV_DISPATCHED = 3'd4;
   localparam logic [2:0] EV_ENQUEUED   = 3'd5;
   localparam logic [2:0] EV_REJECTED   = 3'd6;

   localparam logic OPC_TICK    = 1'b0;
   localparam logic OPC_ENQUEUE = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_POP,
      OP_PUSH,
      OP_AGE,
      OP_COMPACT
   } op_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] work;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] wait_time;
   } slot_type;

   typedef struct packed {
      logic     valid;
      logic     dead;
      slot_type slot;
   } cell_type;

   typedef struct packed {
      logic     empty;
      logic     full;
      logic     has_dead;
      slot_type head;
   } level_status_type;
endpackage
`default_nettype wire

[hdl/dmfs_cell.sv]
// one queue slot: shifts toward the head, takes a push at the tail, ages
`default_nettype none
module dmfs_cell (
   input  wire               clock,
   input  wire               reset,
   input  dmfs_pkg::op_type  op,
   input  dmfs_pkg::slot_type push_slot,
   input  dmfs_pkg::cell_type upper,
   input  wire               lower_valid,
   input  wire               dead_below_in,
   output dmfs_pkg::cell_type cell_out,
   output logic              dead_below_out
);
   dmfs_pkg::cell_type cell_ff, cell_in;

   assign cell_out = cell_ff;
   assign dead_below_out = dead_below_in | (cell_ff.valid & cell_ff.dead);

   always_comb begin
      cell_in = cell_ff;
      case (op)
         dmfs_pkg::OP_POP: begin
            cell_in = upper;
         end
         dmfs_pkg::OP_PUSH: begin
            if (!cell_ff.valid && lower_valid) begin
               cell_in.valid = 1'b1;
               cell_in.dead  = 1'b0;
               cell_in.slot  = push_slot;
            end
         end
         dmfs_pkg::OP_AGE: begin
            if (cell_ff.valid) begin
               if (cell_ff.slot.wait_time != '1) begin
                  cell_in.slot.wait_time = cell_ff.slot.wait_time + 1'b1;
               end
               if (cell_ff.slot.deadline <= dmfs_pkg::TIME_BITS'(1)) begin
                  cell_in.dead = 1'b1;
               end else begin
                  cell_in.slot.deadline = cell_ff.slot.deadline - 1'b1;
               end
            end
         end
         dmfs_pkg::OP_COMPACT: begin
            // everything from the first dead slot upward moves down one
            if (dead_below_out) begin
               cell_in = upper;
            end
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
         cell_ff.dead  <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end
endmodule
`default_nettype wire

[hdl/dmfs_level.sv]
// one level queue built as a row of slot cells
`default_nettype none
module dmfs_level (
   input  wire                        clock,
   input  wire                        reset,
   input  dmfs_pkg::op_type           op,
   input  dmfs_pkg::slot_type         push_slot,
   output dmfs_pkg::level_status_type status
);
   dmfs_pkg::cell_type cells [dmfs_pkg::QUEUE_DEPTH];
   logic dead_chain [dmfs_pkg::QUEUE_DEPTH+1];

   assign dead_chain[0] = 1'b0;

   for (genvar i = 0; i < dmfs_pkg::QUEUE_DEPTH; i++) begin : g_cell
      dmfs_pkg::cell_type upper;
      logic lower_valid;
      if (i == dmfs_pkg::QUEUE_DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = cells[i+1];
      end
      if (i == 0) begin : g_head
         assign lower_valid = 1'b1;
      end else begin : g_body
         assign lower_valid = cells[i-1].valid;
      end
      dmfs_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .op             (op),
         .push_slot      (push_slot),
         .upper          (upper),
         .lower_valid    (lower_valid),
         .dead_below_in  (dead_chain[i]),
         .cell_out       (cells[i]),
         .dead_below_out (dead_chain[i+1])
      );
   end

   assign status.empty    = !cells[0].valid;
   assign status.full     = cells[dmfs_pkg::QUEUE_DEPTH-1].valid;
   assign status.has_dead = dead_chain[dmfs_pkg::QUEUE_DEPTH];
   assign status.head     = cells[0].slot;
endmodule
`default_nettype wire

[hdl/deadline_multilevel_feedback_scheduler_top.sv]
// deadline-aware multilevel feedback queue scheduler, top level
// an enqueue word passes through the EXEC and RESP states before its result strobe
// a tick word passes through EXEC, AGE, COMPACT and RESP; COMPACT repeats until no level holds
// a dropped slot, as the compaction pass removes one dropped slot per level per cycle
// one word at a time; busy stays high until the result strobe; results cannot be stalled
// synchronous reset empties all queues, clears counters, quantum 4 and level_count 4
`default_nettype none
`include "deadline_multilevel_feedback_scheduler_top_macros.svh"
module deadline_multilevel_feedback_scheduler_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_opcode,
   input  wire  [1:0]  req_entry_level,
   input  wire  [15:0] req_work_ticks,
   input  wire  [15:0] req_deadline_ticks,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_finished_wait,
   output logic [6:0]  rsp_expired_count,
   output logic [15:0] rsp_completed_total,
   output logic [15:0] rsp_failed_total,
   output logic        rsp_busy_res,
   output logic [6:0]  rsp_queued_total,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int TB = dmfs_pkg::TIME_BITS;
   localparam int LV = dmfs_pkg::LEVELS;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_AGE     = 3'd2;
   localparam logic [2:0] S_COMPACT = 3'd3;
   localparam logic [2:0] S_RESP    = 3'd4;

   localparam logic REG_QUANTUM     = 1'b0;
   localparam logic REG_LEVEL_COUNT = 1'b1;

   logic [2:0] state_ff, state_in;
   logic [15:0] quantum_ff;
   logic [2:0] level_count_ff;

   logic opcode_ff;
   logic [1:0] level_ff;
   logic [TB-1:0] work_ff, deadline_ff;

   dmfs_pkg::slot_type run_ff, run_in;
   logic [dmfs_pkg::LEVEL_W-1:0] run_level_ff, run_level_in;
   logic run_valid_ff, run_valid_in;
   logic [15:0] quantum_left_ff, quantum_left_in;
   logic [15:0] completed_ff, completed_in;
   logic [15:0] failed_ff, failed_in;
   logic [dmfs_pkg::QCOUNT_W-1:0] queued_ff, queued_in;
   logic [2:0] event_ff, event_in;
   logic [15:0] fin_wait_ff, fin_wait_in;
   logic [6:0] expired_ff, expired_in;

   logic rsp_valid_ff;
   logic [2:0] rsp_event_ff;
   logic [15:0] rsp_fin_ff, rsp_completed_ff, rsp_failed_ff;
   logic [6:0] rsp_expired_ff, rsp_queued_ff;
   logic rsp_busy_ff;

   dmfs_pkg::op_type level_op [LV];
   dmfs_pkg::level_status_type level_stat [LV];
   dmfs_pkg::slot_type push_slot;

   logic [dmfs_pkg::NLEV_W-1:0] nlev;
   logic [dmfs_pkg::NDEAD_W-1:0] ndead;
   logic accept;

   for (genvar l = 0; l < LV; l++) begin : g_level
      dmfs_level u_level (
         .clock     (clock),
         .reset     (reset),
         .op        (level_op[l]),
         .push_slot (push_slot),
         .status    (level_stat[l])
      );
   end

   assign accept = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign pready = 1'b1;

   always_comb begin
      if (level_count_ff == 3'd0) begin
         nlev = dmfs_pkg::NLEV_W'(1);
      end else if (int'(level_count_ff) > LV) begin
         nlev = dmfs_pkg::NLEV_W'(LV);
      end else begin
         nlev = dmfs_pkg::NLEV_W'(level_count_ff);
      end
   end

   always_comb begin
      ndead = '0;
      for (int l = 0; l < LV; l++) begin
         ndead = ndead + dmfs_pkg::NDEAD_W'(level_stat[l].has_dead);
      end
   end

   always_comb begin
      logic [TB-1:0] nw, nd;
      logic [15:0] nq;
      logic [dmfs_pkg::LEVEL_W-1:0] dl;
      logic found;
      int fsum, esum;
      state_in        = state_ff;
      run_in          = run_ff;
      run_level_in    = run_level_ff;
      run_valid_in    = run_valid_ff;
      quantum_left_in = quantum_left_ff;
      completed_in    = completed_ff;
      failed_in       = failed_ff;
      queued_in       = queued_ff;
      event_in        = event_ff;
      fin_wait_in     = fin_wait_ff;
      expired_in      = expired_ff;
      push_slot       = '0;
      nw = '0;
      nd = '0;
      nq = '0;
      dl = '0;
      found = 1'b0;
      fsum = 0;
      esum = 0;
      for (int l = 0; l < LV; l++) begin
         level_op[l] = dmfs_pkg::OP_HOLD;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_EXEC;
               event_in    = dmfs_pkg::EV_NONE;
               fin_wait_in = '0;
               expired_in  = '0;
            end
         end
         S_EXEC: begin
            if (opcode_ff == dmfs_pkg::OPC_ENQUEUE) begin
               state_in = S_RESP;
               push_slot.work      = work_ff;
               push_slot.deadline  = deadline_ff;
               push_slot.wait_time = '0;
               if (work_ff == '0 || deadline_ff == '0 || int'(level_ff) >= int'(nlev)) begin
                  event_in = dmfs_pkg::EV_REJECTED;
               end else if (level_stat[dmfs_pkg::LEVEL_W'(level_ff)].full) begin
                  event_in = dmfs_pkg::EV_REJECTED;
               end else begin
                  event_in = dmfs_pkg::EV_ENQUEUED;
                  level_op[dmfs_pkg::LEVEL_W'(level_ff)] = dmfs_pkg::OP_PUSH;
                  queued_in = queued_ff + 1'b1;
               end
            end else begin
               state_in = S_AGE;
               if (run_valid_ff) begin
                  nw = (run_ff.work != '0) ? run_ff.work - 1'b1 : '0;
                  nd = (run_ff.deadline != '0) ? run_ff.deadline - 1'b1 : '0;
                  nq = (quantum_left_ff != '0) ? quantum_left_ff - 1'b1 : '0;
                  quantum_left_in = nq;
                  run_in.work     = nw;
                  run_in.deadline = nd;
                  if (nw == '0) begin
                     event_in     = dmfs_pkg::EV_COMPLETED;
                     fin_wait_in  = 16'(run_ff.wait_time);
                     completed_in = (completed_ff != 16'hFFFF) ? completed_ff + 1'b1
                                                               : completed_ff;
                     run_valid_in = 1'b0;
                  end else if (nq == '0) begin
                     dl = run_level_ff;
                     if (int'(run_level_ff) + 1 < int'(nlev)) begin
                        dl = run_level_ff + 1'b1;
                     end
                     run_level_in = dl;
                     run_valid_in = 1'b0;
                     push_slot.work      = nw;
                     push_slot.deadline  = nd;
                     push_slot.wait_time = run_ff.wait_time;
                     if (!level_stat[dl].full) begin
                        event_in     = dmfs_pkg::EV_DEMOTED;
                        level_op[dl] = dmfs_pkg::OP_PUSH;
                        queued_in    = queued_ff + 1'b1;
                     end else begin
                        event_in  = dmfs_pkg::EV_FAILED;
                        failed_in = (failed_ff != 16'hFFFF) ? failed_ff + 1'b1 : failed_ff;
                     end
                  end else if (nd == '0) begin
                     event_in     = dmfs_pkg::EV_FAILED;
                     failed_in    = (failed_ff != 16'hFFFF) ? failed_ff + 1'b1 : failed_ff;
                     run_valid_in = 1'b0;
                  end
               end else begin
                  for (int l = 0; l < LV; l++) begin
                     if (!found && l < int'(nlev) && !level_stat[l].empty) begin
                        found           = 1'b1;
                        level_op[l]     = dmfs_pkg::OP_POP;
                        run_in          = level_stat[l].head;
                        run_level_in    = dmfs_pkg::LEVEL_W'(l);
                        run_valid_in    = 1'b1;
                        quantum_left_in = (quantum_ff != '0) ? quantum_ff : 16'd1;
                        event_in        = dmfs_pkg::EV_DISPATCHED;
                        queued_in       = queued_ff - 1'b1;
                     end
                  end
               end
            end
         end
         S_AGE: begin
            state_in = S_COMPACT;
            for (int l = 0; l < LV; l++) begin
               if (l < int'(nlev)) begin
                  level_op[l] = dmfs_pkg::OP_AGE;
               end
            end
         end
         S_COMPACT: begin
            for (int l = 0; l < LV; l++) begin
               level_op[l] = dmfs_pkg::OP_COMPACT;
            end
            if (ndead == '0) begin
               state_in = S_RESP;
            end else begin
               fsum = int'(failed_ff) + int'(ndead);
               esum = int'(expired_ff) + int'(ndead);
               failed_in  = (fsum > 65535) ? 16'hFFFF : 16'(fsum);
               expired_in = (esum > 127) ? 7'd127 : 7'(esum);
               queued_in  = queued_ff - dmfs_pkg::QCOUNT_W'(ndead);
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         run_valid_ff    <= 1'b0;
         run_level_ff    <= '0;
         run_ff          <= '0;
         quantum_left_ff <= '0;
         completed_ff    <= '0;
         failed_ff       <= '0;
         queued_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         run_valid_ff    <= run_valid_in;
         run_level_ff    <= run_level_in;
         run_ff          <= run_in;
         quantum_left_ff <= quantum_left_in;
         completed_ff    <= completed_in;
         failed_ff       <= failed_in;
         queued_ff       <= queued_in;
         rsp_valid_ff    <= (state_ff == S_RESP);
      end
   end

   // word fields and per-item results
   always_ff @(posedge clock) begin
      event_ff    <= event_in;
      fin_wait_ff <= fin_wait_in;
      expired_ff  <= expired_in;
      if (accept) begin
         opcode_ff   <= req_opcode;
         level_ff    <= req_entry_level;
         work_ff     <= TB'(req_work_ticks);
         deadline_ff <= TB'(req_deadline_ticks);
      end
      if (state_ff == S_RESP) begin
         rsp_event_ff     <= event_ff;
         rsp_fin_ff       <= fin_wait_ff;
         rsp_expired_ff   <= expired_ff;
         rsp_completed_ff <= completed_ff;
         rsp_failed_ff    <= failed_ff;
         rsp_busy_ff      <= run_valid_ff;
         rsp_queued_ff    <= (int'(queued_ff) > 127) ? 7'd127 : 7'(queued_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff     <= 16'd4;
         level_count_ff <= 3'd4;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_QUANTUM) begin
            quantum_ff <= pwdata[15:0];
         end else begin
            level_count_ff <= pwdata[2:0];
         end
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_QUANTUM:     prdata = {16'd0, quantum_ff};
         REG_LEVEL_COUNT: prdata = {29'd0, level_count_ff};
         default:         prdata = '0;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_event_ff;
   assign rsp_finished_wait   = rsp_fin_ff;
   assign rsp_expired_count   = rsp_expired_ff;
   assign rsp_completed_total = rsp_completed_ff;
   assign rsp_failed_total    = rsp_failed_ff;
   assign rsp_busy_res        = rsp_busy_ff;
   assign rsp_queued_total    = rsp_queued_ff;

   `DMFS_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy)
   `DMFS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `DMFS_ASSERT_NOW(a_queued_bound, clock, reset, 1'b1,
                    queued_ff <= dmfs_pkg::QCOUNT_W'(LV * dmfs_pkg::QUEUE_DEPTH))
   `DMFS_ASSERT_NOW(a_run_quantum, clock, reset, run_valid_ff, quantum_left_ff != 16'd0)
endmodule
`default_nettype wire
